[src/bta_pkg.sv]
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types and codes for the boundary tag allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bta_pkg;

    // operation codes
    localparam logic [1:0] FUNC_INIT  = 2'd0;
    localparam logic [1:0] FUNC_ALLOC = 2'd1;
    localparam logic [1:0] FUNC_FREE  = 2'd2;

    // status codes
    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_NOFIT = 1'b1;

    // command transaction
    typedef struct packed {
        logic [1:0]  func;
        logic [12:0] request_bytes;
        logic [11:0] free_offset;
    } t_cmd;

    // result transaction
    typedef struct packed {
        logic        status;
        logic [11:0] block_offset;
    } t_rsp;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_A_RD,
        ST_A_EV,
        ST_F_RD,
        ST_F_EV,
        ST_F_NRD,
        ST_F_NEV,
        ST_WR
    } t_state;

endpackage

`default_nettype wire

[src/boundary_tag_allocator_core.sv]
// ----------------------------------------------------------------------------
// boundary_tag_allocator_core
// First-fit boundary tag heap allocator built around one tag memory.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears on o_rsp for one cycle with o_rsp_valid and cannot be held off.
// Allocate walks blocks from the top through their end tags, each in a memory
// read state and then an evaluate state, and on a fit writes two or four tags.
// Free walks from the bottom through start tags the same way, reads the upper
// neighbor, if any, in its own read and evaluate states, and on a valid free
// writes two tags. Reinitialize writes the two initial tags. The registered
// tag memory read sets the pace of each walk. After reset the block is busy
// while it writes the initial free block tags.
`default_nettype none

module boundary_tag_allocator_core #(
    parameter int HEAP_WORDS = 1024
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             start,
    input  bta_pkg::t_cmd   i_cmd,
    output logic            busy,
    output logic            o_rsp_valid,
    output bta_pkg::t_rsp   o_rsp
);
    import bta_pkg::*;

    localparam int AW = $clog2(HEAP_WORDS);
    localparam int TW = AW + 1;
    localparam int CW = ((AW > 11) ? AW : 11) + 3;
    localparam logic signed [CW-1:0] C_HW = CW'(HEAP_WORDS);

    // tag memory
    logic signed [TW-1:0] mem [0:HEAP_WORDS-1];
    logic signed [TW-1:0] r_rdata;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [TW-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    // control and working registers
    t_state r_state, n_state;
    logic signed [CW-1:0] r_e, n_e;
    logic signed [CW-1:0] r_n, n_n;
    logic signed [CW-1:0] r_p, n_p;
    logic signed [CW-1:0] r_prev, n_prev;
    logic signed [CW-1:0] r_prev_tag, n_prev_tag;
    logic                 r_prev_vld, n_prev_vld;
    logic signed [CW-1:0] r_start, n_start;
    logic signed [CW-1:0] r_end, n_end;
    logic signed [CW-1:0] r_size, n_size;
    logic [AW-1:0]        r_wa [0:3];
    logic signed [TW-1:0] r_wd [0:3];
    logic [AW-1:0]        n_wa [0:3];
    logic signed [TW-1:0] n_wd [0:3];
    logic [2:0]           r_wn, n_wn;
    logic [1:0]           r_wi, n_wi;
    logic                 r_quiet, n_quiet;
    t_rsp                 r_rsp, n_rsp;
    logic                 r_vld, n_vld;

    // shared decode
    logic                 accept;
    logic signed [CW-1:0] t, s, a, e_nx, nx, fs, fe;
    logic signed [CW-1:0] bsum;
    logic                 a_hit, a_fail, f_over, f_match, f_past, f_nx_ok;
    logic                 n_ok, wr_last;

    always_comb begin
        accept  = start && (r_state == ST_IDLE);
        t       = CW'(r_rdata);
        s       = (t < 0) ? -t : t;
        a       = r_e - s - CW'(2);
        e_nx    = r_e - s - CW'(4);
        a_hit   = (a >= 0) && (t >= r_n);
        a_fail  = (a < 0) || ((t < r_n) && (e_nx < CW'(2)));
        nx      = r_e + s + CW'(4);
        f_over  = (r_e + s + CW'(4)) > C_HW;
        f_match = (r_e + CW'(2)) == r_p;
        f_past  = (r_e + CW'(2)) > r_p;
        f_nx_ok = (nx + CW'(4)) <= C_HW;
        n_ok    = (t >= 0) && ((r_e + t + CW'(4)) <= C_HW);
        fs      = n_ok ? (r_size + t + CW'(4)) : r_size;
        fe      = n_ok ? (r_e + t + CW'(2)) : r_end;
        bsum    = CW'({1'b0, i_cmd.request_bytes} + 14'd3) >>> 2;
        wr_last = (r_wi == 2'(r_wn - 3'd1));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.func)
                        FUNC_INIT:  n_state = ST_WR;
                        FUNC_ALLOC: n_state = ST_A_RD;
                        FUNC_FREE:  n_state = (i_cmd.free_offset[1:0] != 2'b00) ?
                                              ST_IDLE : ST_F_RD;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_A_RD: n_state = ST_A_EV;
            ST_A_EV: begin
                if (a_fail)     n_state = ST_IDLE;
                else if (a_hit) n_state = ST_WR;
                else            n_state = ST_A_RD;
            end
            ST_F_RD: n_state = ST_F_EV;
            ST_F_EV: begin
                if (f_over) begin
                    n_state = ST_IDLE;
                end else if (f_match) begin
                    if (t >= 0)       n_state = ST_IDLE;
                    else if (f_nx_ok) n_state = ST_F_NRD;
                    else              n_state = ST_WR;
                end else if (f_past || !f_nx_ok) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_F_RD;
                end
            end
            ST_F_NRD: n_state = ST_F_NEV;
            ST_F_NEV: n_state = ST_WR;
            ST_WR:    n_state = wr_last ? ST_IDLE : ST_WR;
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_e        = r_e;
        n_n        = r_n;
        n_p        = r_p;
        n_prev     = r_prev;
        n_prev_tag = r_prev_tag;
        n_prev_vld = r_prev_vld;
        n_start    = r_start;
        n_end      = r_end;
        n_size     = r_size;
        n_wa       = r_wa;
        n_wd       = r_wd;
        n_wn       = r_wn;
        n_wi       = r_wi;
        n_quiet    = r_quiet;
        n_rsp      = r_rsp;
        n_vld      = 1'b0;
        rd_addr    = AW'(r_e);
        wr_en      = 1'b0;
        wr_addr    = r_wa[r_wi];
        wr_data    = r_wd[r_wi];
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_rsp   = '{status: STAT_OK, block_offset: 12'd0};
                    n_quiet = 1'b0;
                    n_wi    = 2'd0;
                    case (i_cmd.func)
                        FUNC_INIT: begin
                            n_wa[0] = AW'(0);
                            n_wd[0] = TW'(C_HW - CW'(4));
                            n_wa[1] = AW'(C_HW - CW'(2));
                            n_wd[1] = TW'(C_HW - CW'(4));
                            n_wn    = 3'd2;
                        end
                        FUNC_ALLOC: begin
                            n_n = (bsum == 0) ? CW'(1) : bsum;
                            n_e = C_HW - CW'(2);
                        end
                        FUNC_FREE: begin
                            n_p        = CW'({2'b00, i_cmd.free_offset[11:2]});
                            n_e        = '0;
                            n_prev_vld = 1'b0;
                            n_vld      = (i_cmd.free_offset[1:0] != 2'b00);
                        end
                        default: n_vld = 1'b1;
                    endcase
                end
            end
            ST_A_EV: begin
                if (a_fail) begin
                    n_rsp = '{status: STAT_NOFIT, block_offset: 12'd0};
                    n_vld = 1'b1;
                end else if (a_hit) begin
                    if ((s - r_n) < CW'(4)) begin
                        n_wa[0] = AW'(a);
                        n_wd[0] = TW'(-s);
                        n_wa[1] = AW'(r_e);
                        n_wd[1] = TW'(-s);
                        n_wn    = 3'd2;
                        n_rsp.block_offset = {10'(a + CW'(2)), 2'b00};
                    end else begin
                        n_wa[0] = AW'(r_e);
                        n_wd[0] = TW'(-r_n);
                        n_wa[1] = AW'(r_e - r_n - CW'(2));
                        n_wd[1] = TW'(-r_n);
                        n_wa[2] = AW'(a);
                        n_wd[2] = TW'(s - r_n - CW'(4));
                        n_wa[3] = AW'(r_e - r_n - CW'(4));
                        n_wd[3] = TW'(s - r_n - CW'(4));
                        n_wn    = 3'd4;
                        n_rsp.block_offset = {10'(r_e - r_n), 2'b00};
                    end
                end else begin
                    n_e = e_nx;
                end
            end
            ST_F_EV: begin
                if (f_over) begin
                    n_vld = 1'b1;
                end else if (f_match) begin
                    if (t >= 0) begin
                        n_vld = 1'b1;
                    end else begin
                        n_start = r_e;
                        n_end   = r_e + s + CW'(2);
                        n_size  = s;
                        if (r_prev_vld && (r_prev_tag >= 0)) begin
                            n_start = r_prev;
                            n_size  = s + r_prev_tag + CW'(4);
                        end
                        if (f_nx_ok) begin
                            n_e = nx;
                        end else begin
                            n_wa[0] = AW'(n_start);
                            n_wd[0] = TW'(n_size);
                            n_wa[1] = AW'(n_end);
                            n_wd[1] = TW'(n_size);
                            n_wn    = 3'd2;
                        end
                    end
                end else if (f_past || !f_nx_ok) begin
                    n_vld = 1'b1;
                end else begin
                    n_prev     = r_e;
                    n_prev_tag = t;
                    n_prev_vld = 1'b1;
                    n_e        = nx;
                end
            end
            ST_F_NEV: begin
                n_wa[0] = AW'(r_start);
                n_wd[0] = TW'(fs);
                n_wa[1] = AW'(fe);
                n_wd[1] = TW'(fs);
                n_wn    = 3'd2;
            end
            ST_WR: begin
                wr_en = 1'b1;
                n_wi  = r_wi + 2'd1;
                n_vld = wr_last && !r_quiet;
            end
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WR;
            r_quiet <= 1'b1;
            r_vld   <= 1'b0;
            r_wi    <= 2'd0;
            r_wn    <= 3'd2;
            r_wa[0] <= AW'(0);
            r_wd[0] <= TW'(C_HW - CW'(4));
            r_wa[1] <= AW'(C_HW - CW'(2));
            r_wd[1] <= TW'(C_HW - CW'(4));
        end else begin
            r_state <= n_state;
            r_quiet <= n_quiet;
            r_vld   <= n_vld;
            r_wi    <= n_wi;
            r_wn    <= n_wn;
            r_wa    <= n_wa;
            r_wd    <= n_wd;
        end
        r_e        <= n_e;
        r_n        <= n_n;
        r_p        <= n_p;
        r_prev     <= n_prev;
        r_prev_tag <= n_prev_tag;
        r_prev_vld <= n_prev_vld;
        r_start    <= n_start;
        r_end      <= n_end;
        r_size     <= n_size;
        r_rsp      <= n_rsp;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_rsp_valid = r_vld;
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire

[src/bta_checker.sv]
// ----------------------------------------------------------------------------
// bta_checker
// Port-level checks for the boundary tag allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bta_checker (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           start,
    input wire           busy,
    input wire           o_rsp_valid,
    input bta_pkg::t_rsp o_rsp
);
    import bta_pkg::*;

    // a result only follows an accepted transaction or the end of a busy span
    a_rsp_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> $past(busy || start))
        else $error("result without a transaction");

    // the block is free again when a result is shown
    a_rsp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !busy)
        else $error("result while busy");

    // an accepted transaction either completes at once or keeps the block busy
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_rsp_valid))
        else $error("transaction dropped");

    // a failed allocation grants nothing, and grants are word aligned
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> ((o_rsp.status == STAT_OK) ? (o_rsp.block_offset[1:0] == 2'b00)
                                                   : (o_rsp.block_offset == 12'd0)))
        else $error("bad result offset");

endmodule

bind boundary_tag_allocator_core bta_checker u_bta_checker (.*);

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the boundary tag heap allocator core.
// ----------------------------------------------------------------------------
// A behavioral copy of the tag heap predicts the response of every accepted
// command. Directed cases cover edge sizes, exact and near fits, zero-size
// remainders, bad frees and coalescing on both sides. Random traffic then
// mixes allocates and frees of live blocks with noise commands. The sender
// idles in random bursts, but not in the last traffic run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import bta_pkg::*;

    localparam int HEAP_WORDS  = 1024;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    t_cmd  i_cmd = '0;
    logic  busy;
    logic  o_rsp_valid;
    t_rsp  o_rsp;

    boundary_tag_allocator_core #(.HEAP_WORDS(HEAP_WORDS)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_cmd      (i_cmd),
        .busy       (busy),
        .o_rsp_valid(o_rsp_valid),
        .o_rsp      (o_rsp)
    );

    always #4 i_clk = ~i_clk;

    // heap shadow and expected responses
    int          heap_tags [HEAP_WORDS];
    t_rsp        rsp_expected [$];
    logic [11:0] live_blocks [$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          idle_enable = 1'b1;

    function automatic int tag_abs(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void heap_rebuild();
        foreach (heap_tags[i]) heap_tags[i] = 0;
        heap_tags[0] = HEAP_WORDS - 4;
        heap_tags[HEAP_WORDS - 2] = HEAP_WORDS - 4;
    endfunction

    // first fit from the top, carving from the high end
    function automatic logic heap_grant(int bytes, output int off);
        int n, e, t, s, a, r;
        n = (bytes + 3) >> 2;
        e = HEAP_WORDS - 2;
        off = 0;
        if (n == 0) n = 1;
        while (e >= 2) begin
            t = heap_tags[e];
            s = tag_abs(t);
            a = e - s - 2;
            if (a < 0) break;
            if (t >= n) begin
                if (s - n < 4) begin
                    heap_tags[a] = -s;
                    heap_tags[e] = -s;
                    off = (a + 2) * 4;
                end else begin
                    r = s - n - 4;
                    heap_tags[e] = -n;
                    heap_tags[e - n - 2] = -n;
                    heap_tags[a] = r;
                    heap_tags[e - n - 4] = r;
                    off = (e - n) * 4;
                end
                return STAT_OK;
            end
            e = e - s - 4;
        end
        return STAT_NOFIT;
    endfunction

    // release with coalescing; bad offsets leave the heap alone
    function automatic void heap_release(int off);
        int p, pos, prev, s, first, last, size, nx, ns;
        pos = 0;
        prev = -1;
        if (off % 4 != 0) return;
        p = off / 4;
        while (pos + 4 <= HEAP_WORDS) begin
            s = tag_abs(heap_tags[pos]);
            if (pos + s + 4 > HEAP_WORDS) return;
            if (pos + 2 == p) begin
                first = pos;
                last = pos + s + 2;
                size = s;
                nx = pos + s + 4;
                if (heap_tags[pos] >= 0) return;
                if (prev >= 0 && heap_tags[prev] >= 0) begin
                    first = prev;
                    size += heap_tags[prev] + 4;
                end
                if (nx + 4 <= HEAP_WORDS && heap_tags[nx] >= 0) begin
                    ns = heap_tags[nx];
                    if (nx + ns + 4 <= HEAP_WORDS) begin
                        size += ns + 4;
                        last = nx + ns + 2;
                    end
                end
                heap_tags[first] = size;
                heap_tags[last] = size;
                return;
            end
            if (pos + 2 > p) return;
            prev = pos;
            pos = pos + s + 4;
        end
    endfunction

    function automatic t_rsp heap_apply(t_cmd c);
        t_rsp rsp;
        int   off;
        rsp = '0;
        case (c.func)
            FUNC_INIT: begin
                heap_rebuild();
                live_blocks.delete();
            end
            FUNC_ALLOC: begin
                rsp.status = heap_grant(int'(c.request_bytes), off);
                if (rsp.status == STAT_OK) begin
                    rsp.block_offset = off[11:0];
                    live_blocks.push_back(off[11:0]);
                end
            end
            FUNC_FREE: heap_release(int'(c.free_offset));
            default: ;
        endcase
        return rsp;
    endfunction

    // send one transaction; start stays high for the caller to reuse
    task automatic send_cmd(logic [1:0] func, int bytes, int off);
        t_cmd c;
        c.func = func;
        c.request_bytes = bytes[12:0];
        c.free_offset = off[11:0];
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        rsp_expected.push_back(heap_apply(c));
    endtask

    task automatic maybe_idle();
        int gap;
        if (idle_enable && $urandom_range(3) == 0) begin
            gap = $urandom_range(17, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (rsp_expected.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // response checker
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_rsp_valid) begin
            if (rsp_expected.size() == 0) begin
                $display("%0t: unexpected response %h", $time, o_rsp);
                error_count++;
            end else begin
                exp_rsp = rsp_expected.pop_front();
                if (o_rsp.status !== exp_rsp.status) begin
                    $display("%0t: status expected %h actual %h",
                             $time, exp_rsp.status, o_rsp.status);
                    error_count++;
                end
                if (o_rsp.block_offset !== exp_rsp.block_offset) begin
                    $display("%0t: block_offset expected %h actual %h",
                             $time, exp_rsp.block_offset, o_rsp.block_offset);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic test_edges();
        send_cmd(FUNC_INIT, 0, 0);
        send_cmd(FUNC_ALLOC, 0, 0);
        send_cmd(FUNC_ALLOC, 1, 0);
        send_cmd(FUNC_ALLOC, 4096, 0);
        send_cmd(FUNC_ALLOC, 8191, 0);
        send_cmd(FUNC_FREE, 4084, 0 + 4084);
        send_cmd(FUNC_FREE, 0, 4085);
        send_cmd(FUNC_FREE, 0, 0);
        send_cmd(FUNC_SPARE, 8191, 4095);
    endtask

    task automatic test_fits();
        // exact fit, near fit, then a zero-size remainder
        send_cmd(FUNC_INIT, 0, 0);
        send_cmd(FUNC_ALLOC, 4080, 0);
        send_cmd(FUNC_FREE, 0, 8);
        send_cmd(FUNC_ALLOC, 4068, 0);
        send_cmd(FUNC_FREE, 0, 8);
        send_cmd(FUNC_ALLOC, 4064, 0);
        send_cmd(FUNC_ALLOC, 4, 0);
        send_cmd(FUNC_FREE, 0, 24);
    endtask

    task automatic test_coalesce();
        int a, b, c;
        send_cmd(FUNC_INIT, 0, 0);
        send_cmd(FUNC_ALLOC, 40, 0);
        a = live_blocks[$];
        send_cmd(FUNC_ALLOC, 40, 0);
        b = live_blocks[$];
        send_cmd(FUNC_ALLOC, 40, 0);
        c = live_blocks[$];
        send_cmd(FUNC_FREE, 0, a);
        send_cmd(FUNC_FREE, 0, c);
        send_cmd(FUNC_FREE, 0, b);
    endtask

    task automatic test_traffic(int count);
        int sel, idx, bytes;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            if (sel < 50) begin
                case ($urandom_range(9))
                    0:       bytes = $urandom_range(8191);
                    1, 2:    bytes = $urandom_range(4096);
                    default: bytes = $urandom_range(160);
                endcase
                send_cmd(FUNC_ALLOC, bytes, $urandom_range(4095));
            end else if (sel < 88 && live_blocks.size() != 0) begin
                idx = $urandom_range(live_blocks.size() - 1);
                send_cmd(FUNC_FREE, $urandom_range(8191), live_blocks[idx]);
                live_blocks.delete(idx);
            end else if (sel < 96) begin
                send_cmd(FUNC_FREE, $urandom_range(8191), $urandom_range(4095));
            end else if (sel < 98) begin
                send_cmd(FUNC_SPARE, $urandom_range(8191), $urandom_range(4095));
            end else begin
                send_cmd(FUNC_INIT, $urandom_range(8191), $urandom_range(4095));
            end
            maybe_idle();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        heap_rebuild();
        @(posedge i_clk);

        test_edges();
        test_fits();
        test_coalesce();
        test_traffic(300);
        // hold off until every response is in
        wait_drained();
        test_traffic(250);
        idle_enable = 1'b0;
        test_traffic(130);
        start <= 1'b0;

        while (rsp_expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
src/bta_pkg.sv
src/boundary_tag_allocator_core.sv
src/bta_checker.sv
tb/sv/tb_top.sv
